// ===== rtl/core/imh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
    localparam int Capacity  = 256;
    localparam int KeyBits   = 32;
    localparam int SlotBits  = $clog2(Capacity);
    localparam int FillBits  = $clog2(Capacity + 1);
    localparam int HandleBits = 8;
    localparam int HandleCount = 256;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef logic [SlotBits-1:0] t_slot;
    typedef logic [FillBits-1:0] t_fill;
    typedef logic [KeyBits-1:0]  t_key;
    typedef logic [HandleBits-1:0] t_handle;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,     // latch the item, read slot_of_handle and presence
        CMD_RD_TOP,    // decide the operation from presence and fill
        CMD_RD_LAST,   // read the last entry
        CMD_PLACE,     // take the last entry as the one to sift
        CMD_RD_KIDS_L, // read left child
        CMD_RD_KIDS_R, // read right child
        CMD_DOWN,      // compare with children and swap when needed
        CMD_RD_PAR,    // read parent
        CMD_UP,        // compare with parent, move it down or settle the entry
        CMD_FINISH     // load the result register
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       failed;
        logic       present;
        logic       in_range;
        logic       empty;
        logic       full;
        logic       is_last;
        logic       has_left;
        logic       has_right;
        logic       down_swap;
        logic       up_swap;
        logic       at_root;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/imh_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface imh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] key;
    logic [7:0]  handle;
    modport source (output valid, op, key, handle, input ready);
    modport sink   (input valid, op, key, handle, output ready);
endinterface

interface imh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  top_handle;
    logic [31:0] top_key;
    logic [8:0]  fill;
    modport source (output valid, status, top_handle, top_key, fill, input ready);
    modport sink   (input valid, status, top_handle, top_key, fill, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imh_datapath import imh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_key,
    input  wire logic [7:0]  i_handle,
    output t_status          o_stat,
    output logic [1:0]       o_status,
    output logic [7:0]       o_top_handle,
    output logic [31:0]      o_top_key,
    output logic [8:0]       o_fill
);
    // Heap storage: one memory holds key and handle per slot.
    logic [KeyBits+HandleBits-1:0] mem_slot [Capacity];
    t_slot                         mem_pos  [HandleCount];
    logic [HandleCount-1:0]        r_present;

    logic [1:0]  r_op;
    t_handle     r_handle;
    t_key        r_cur_key;   // entry being sifted
    t_handle     r_cur_h;
    t_slot       r_cur;       // slot it occupies
    t_fill       r_count;
    t_slot       r_pos_rd;
    t_key        r_rd_key;
    t_handle     r_rd_h;
    t_key        r_l_key;
    t_handle     r_l_h;
    t_key        r_top_key;
    t_handle     r_top_h;
    logic [1:0]  r_status;
    logic [1:0]  r_res_status;
    t_handle     r_res_top_h;
    t_key        r_res_top_key;
    t_fill       r_res_fill;

    logic [SlotBits:0] left_w, right_w;
    t_slot             rd_addr;
    t_slot             parent;
    logic              right_wins;
    logic              do_wr;
    t_slot             wr_addr;
    t_key              wr_key;
    t_handle           wr_h;

    assign left_w  = {r_cur, 1'b1};
    assign right_w = {r_cur, 1'b0} + (SlotBits+1)'(2);
    assign parent  = t_slot'((r_cur - t_slot'(1)) >> 1);
    assign right_wins = o_stat.has_right && (r_rd_key > r_l_key);

    always_comb begin
        o_stat.op        = r_op;
        o_stat.failed    = (r_status != ST_OK);
        o_stat.present   = r_present[r_handle];
        o_stat.in_range  = {1'b0, r_pos_rd} < r_count;
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count >= t_fill'(Capacity));
        o_stat.is_last   = ({1'b0, r_cur} == r_count - t_fill'(1));
        o_stat.has_left  = {1'b0, left_w} < {1'b0, r_count};
        o_stat.has_right = {1'b0, right_w} < {1'b0, r_count};
        o_stat.down_swap = right_wins ? (r_rd_key > r_cur_key)
                                      : (o_stat.has_left && r_l_key > r_cur_key);
        o_stat.up_swap   = r_rd_key < r_cur_key;
        o_stat.at_root   = (r_cur == '0);
    end

    always_comb begin
        rd_addr = r_cur;
        case (i_cmd)
            CMD_RD_LAST:   rd_addr = t_slot'(r_count - t_fill'(1));
            CMD_RD_KIDS_L: rd_addr = left_w[SlotBits-1:0];
            CMD_RD_KIDS_R: rd_addr = right_w[SlotBits-1:0];
            CMD_RD_PAR:    rd_addr = parent;
            default:       rd_addr = r_cur;
        endcase
    end

    // The sifted entry stays in registers while the slot it passes is refilled by
    // the child or parent that moves; it is written once, where it settles.
    always_comb begin
        do_wr = 1'b0; wr_addr = r_cur; wr_key = r_cur_key; wr_h = r_cur_h;
        case (i_cmd)
            CMD_DOWN: begin
                if (o_stat.down_swap) begin
                    do_wr = 1'b1;
                    wr_key = right_wins ? r_rd_key : r_l_key;
                    wr_h   = right_wins ? r_rd_h : r_l_h;
                end
            end
            CMD_UP: begin
                do_wr = 1'b1;
                if (o_stat.up_swap && !o_stat.at_root) begin
                    wr_key = r_rd_key; wr_h = r_rd_h;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            mem_slot[wr_addr] <= {wr_key, wr_h};
            mem_pos[wr_h]     <= wr_addr;
        end
        {r_rd_key, r_rd_h} <= mem_slot[rd_addr];
        r_pos_rd <= mem_pos[i_cmd == CMD_START ? i_handle : r_handle];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
        end else begin
            case (i_cmd)
                CMD_START: begin
                    r_op <= i_op; r_handle <= i_handle;
                    r_cur_key <= i_key; r_cur_h <= i_handle;
                    r_status <= ST_OK; r_top_key <= '0; r_top_h <= '0;
                end
                CMD_RD_TOP: begin
                    // decide the operation; r_pos_rd and presence now valid
                    case (r_op)
                        OP_INSERT: begin
                            if (r_present[r_handle]) r_status <= ST_ABSENT;
                            else if (o_stat.full) r_status <= ST_FULL;
                            else begin
                                r_cur <= t_slot'(r_count);
                                r_count <= r_count + t_fill'(1);
                                r_present[r_handle] <= 1'b1;
                            end
                        end
                        OP_EXTRACT: begin
                            if (o_stat.empty) r_status <= ST_EMPTY;
                            else r_cur <= '0;
                        end
                        OP_REMOVE: begin
                            if (!r_present[r_handle] || !o_stat.in_range)
                                r_status <= ST_ABSENT;
                            else begin
                                r_cur <= r_pos_rd;
                                r_present[r_handle] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_RD_LAST: begin
                    // r_rd_key holds the slot r_cur (root for extract)
                    if (r_op == OP_EXTRACT) begin
                        r_top_key <= r_rd_key; r_top_h <= r_rd_h;
                        r_present[r_rd_h] <= 1'b0;
                    end
                end
                CMD_PLACE: begin
                    if (r_op != OP_INSERT) begin
                        r_cur_key <= r_rd_key; r_cur_h <= r_rd_h;
                        r_count <= r_count - t_fill'(1);
                    end
                end
                CMD_RD_KIDS_R: begin
                    r_l_key <= r_rd_key; r_l_h <= r_rd_h;
                end
                CMD_DOWN: begin
                    if (o_stat.down_swap)
                        r_cur <= right_wins ? right_w[SlotBits-1:0] : left_w[SlotBits-1:0];
                end
                CMD_UP: begin
                    if (o_stat.up_swap && !o_stat.at_root) r_cur <= parent;
                end
                CMD_FINISH: begin
                    r_res_status <= r_status; r_res_top_h <= r_top_h;
                    r_res_top_key <= r_top_key; r_res_fill <= r_count;
                end
                default: ;
            endcase
        end
    end

    assign o_status     = r_res_status;
    assign o_top_handle = r_res_top_h;
    assign o_top_key    = r_res_top_key;
    assign o_fill       = r_res_fill;
endmodule
`default_nettype wire

// ===== rtl/core/imh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl import imh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_status i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_TOP    = 11'b00000000100,
        S_LAST   = 11'b00000001000,
        S_PLACE  = 11'b00000010000,
        S_KL     = 11'b00000100000,
        S_KR     = 11'b00001000000,
        S_DOWN   = 11'b00010000000,
        S_PAR    = 11'b00100000000,
        S_UP     = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && o_in_ready) begin
                o_cmd = CMD_START; n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd = CMD_RD_TOP;
                n_state = S_TOP;
            end
            S_TOP: begin
                // Status decided and r_cur set; the idle command reads slot r_cur.
                if (i_stat.failed || i_stat.op == OP_UNUSED) n_state = S_DONE;
                else if (i_stat.op == OP_INSERT) n_state = S_PAR;
                else n_state = S_LAST;
            end
            S_LAST: begin
                o_cmd = CMD_RD_LAST; n_state = S_PLACE;
            end
            S_PLACE: begin
                // last entry read; if the freed slot is the last, just shrink
                o_cmd = CMD_PLACE;
                n_state = i_stat.is_last ? S_DONE : S_KL;
            end
            S_KL: begin
                o_cmd = CMD_RD_KIDS_L; n_state = S_KR;
            end
            S_KR: begin
                o_cmd = CMD_RD_KIDS_R; n_state = S_DOWN;
            end
            S_DOWN: begin
                o_cmd = CMD_DOWN;
                if (i_stat.down_swap) n_state = S_KL;
                else n_state = S_PAR;
            end
            S_PAR: begin
                o_cmd = CMD_RD_PAR; n_state = S_UP;
            end
            S_UP: begin
                o_cmd = CMD_UP;
                if (i_stat.up_swap && !i_stat.at_root) n_state = S_PAR;
                else n_state = S_DONE;
            end
            S_DONE: begin
                // Wait here while the previous result still occupies the output.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd = CMD_FINISH; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd == CMD_FINISH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end
`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_out_valid) else $error("result not shown");
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/indexed_max_heap_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Indexed binary max-heap of up to 256 (key, handle) entries with insert,
// extract-maximum and remove-by-handle. One item is worked at a time: after a
// fixed start, each level examined on the way down reads the left child, reads
// the right child and compares, and each level on the way up reads the parent
// and compares, all through the slot memory. The result beat is held in an output
// register and the next item is accepted while it waits; a second finished result
// stalls until the first one is taken. Presence bits clear at reset.
module indexed_max_heap_top import imh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    imh_in_if.sink    i_in,
    imh_out_if.source o_out
);
    t_cmd    cmd;
    t_status stat;
    logic [1:0] st;

    imh_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_stat(stat), .o_cmd(cmd)
    );
    imh_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_op(i_in.op), .i_key(i_in.key), .i_handle(i_in.handle),
        .o_stat(stat), .o_status(st), .o_top_handle(o_out.top_handle),
        .o_top_key(o_out.top_key), .o_fill(o_out.fill)
    );
    assign o_out.status = st;
endmodule
`default_nettype wire
